FILE: rtl/vbacs_pkg.sv
// Shared types, constants and helpers for the Viterbi branch-metric / ACS block.
// No dependencies; imported by every module under rtl/.
package vbacs_pkg;

    localparam int MAX_STATES   = 64;
    localparam int MAX_BRANCHES = 256;
    localparam int MAX_ELEMENTS = 8;
    localparam int REF_ROWS     = 512;
    localparam int SAMPLE_BITS  = 16;

    localparam int STATE_W  = 6;    // state index
    localparam int ROW_W    = 9;    // reference row
    localparam int ELEM_W   = 3;    // element index
    localparam int BIDX_W   = 8;    // branch memory index
    localparam int BCNT_W   = 9;    // branch count / trellis branch counter
    localparam int SCNT_W   = 7;    // state count (up to 64)
    localparam int METRIC_W = 48;
    localparam int BM_W     = 36;
    localparam int SQ_W     = 33;   // one squared difference
    localparam int ACC_W    = 37;   // sum over up to 8 elements, re and im
    localparam int REF_AW   = ROW_W + ELEM_W;

    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 16;

    typedef enum logic [1:0] {
        CMD_LOAD_REF   = 2'd0,
        CMD_SET_METRIC = 2'd1,
        CMD_RX         = 2'd2,
        CMD_NOP        = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        REG_ALPHABET = 3'd0,
        REG_MEMLEN   = 3'd1,
        REG_GROUPS   = 3'd2,
        REG_BRANCHES = 3'd3,
        REG_ELEMENTS = 3'd4,
        REG_BLOCKSYM = 3'd5,
        REG_COMPLEX  = 3'd6,
        REG_UNUSED   = 3'd7
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_BASE,
        ST_BM_RD,
        ST_BM_SQ,
        ST_BM_ACC,
        ST_ACS_RD,
        ST_ACS_CMP,
        ST_ACS_OUT,
        ST_CP_RD,
        ST_CP_WR
    } ctrl_state_t;

    typedef struct packed {
        logic                setup;      // derive reference row shift
        logic                base;       // shift times branch count
        logic                bm_rd;      // read reference entry
        logic                bm_sq;      // square differences
        logic                bm_acc;     // accumulate
        logic                bm_first;   // first element of a branch
        logic                bm_wr;      // last element: store branch metric
        logic                acs_rd;     // read path and branch metric
        logic                acs_cmp;    // add, compare, select
        logic                acs_first;  // first candidate
        logic                acs_out;    // emit result, park new metric
        logic                cp_rd;      // read parked metric
        logic                cp_wr;      // write back path metric
        logic                last;       // final state of the run
        logic [BCNT_W-1:0]   b;
        logic [ELEM_W-1:0]   e;
        logic [STATE_W-1:0]  pv;
        logic [BCNT_W-1:0]   br;
        logic [STATE_W-1:0]  s;
    } ctrl_cmd_t;

    typedef struct packed {
        logic                trigger;    // last element of an interval accepted
        logic                out_free;
        logic [ELEM_W-1:0]   ne_m1;
        logic [BCNT_W-1:0]   nb;
        logic [3:0]          m;
        logic [SCNT_W-1:0]   states;
    } dp_status_t;

    // largest group count that keeps states within MAX_STATES
    function automatic logic [5:0] max_groups(input logic [3:0] m);
        logic [5:0] g;
        unique case (m)
            4'd2:    g = 6'd32;
            4'd3:    g = 6'd21;
            4'd4:    g = 6'd16;
            4'd5:    g = 6'd12;
            4'd6:    g = 6'd10;
            4'd7:    g = 6'd9;
            default: g = 6'd8;
        endcase
        return g;
    endfunction

endpackage

FILE: rtl/vbacs_ctrl.sv
// Sequencer for the branch-metric and add-compare-select passes.
// Depends on vbacs_pkg; drives vbacs_datapath through ctrl_cmd_t.
module vbacs_ctrl
    import vbacs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       idle
);

    ctrl_state_t state_reg, state_next;
    logic [BCNT_W-1:0]  b_reg, b_next;
    logic [ELEM_W-1:0]  e_reg, e_next;
    logic [2:0]         p_reg, p_next;
    logic [SCNT_W-1:0]  pv_reg, pv_next;
    logic [BCNT_W-1:0]  br_reg, br_next;
    logic [STATE_W-1:0] s_reg, s_next;
    logic               s_last;

    assign s_last = ({1'b0, s_reg} == status.states - SCNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            b_reg     <= '0;
            e_reg     <= '0;
            p_reg     <= '0;
            pv_reg    <= '0;
            br_reg    <= '0;
            s_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            b_reg     <= b_next;
            e_reg     <= e_next;
            p_reg     <= p_next;
            pv_reg    <= pv_next;
            br_reg    <= br_next;
            s_reg     <= s_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        b_next     = b_reg;
        e_next     = e_reg;
        p_next     = p_reg;
        pv_next    = pv_reg;
        br_next    = br_reg;
        s_next     = s_reg;
        cmd        = '0;
        cmd.b      = b_reg;
        cmd.e      = e_reg;
        cmd.pv     = pv_reg[STATE_W-1:0];
        cmd.br     = br_reg;
        cmd.s      = s_reg;
        cmd.last   = s_last;
        cmd.bm_first  = (e_reg == '0);
        cmd.bm_wr     = 1'b0;
        cmd.acs_first = (p_reg == '0);
        idle       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (status.trigger)
                begin
                    b_next     = '0;
                    e_next     = '0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                cmd.base   = 1'b1;
                state_next = ST_BM_RD;
            end
            ST_BM_RD:
            begin
                cmd.bm_rd  = 1'b1;
                state_next = ST_BM_SQ;
            end
            ST_BM_SQ:
            begin
                cmd.bm_sq  = 1'b1;
                state_next = ST_BM_ACC;
            end
            ST_BM_ACC:
            begin
                cmd.bm_acc = 1'b1;
                if (e_reg == status.ne_m1)
                begin
                    cmd.bm_wr = 1'b1;
                    e_next    = '0;
                    if (b_reg == status.nb - BCNT_W'(1))
                    begin
                        p_next     = '0;
                        pv_next    = '0;
                        br_next    = '0;
                        s_next     = '0;
                        state_next = ST_ACS_RD;
                    end
                    else
                    begin
                        b_next     = b_reg + BCNT_W'(1);
                        state_next = ST_BM_RD;
                    end
                end
                else
                begin
                    e_next     = e_reg + ELEM_W'(1);
                    state_next = ST_BM_RD;
                end
            end
            ST_ACS_RD:
            begin
                cmd.acs_rd = 1'b1;
                state_next = ST_ACS_CMP;
            end
            ST_ACS_CMP:
            begin
                cmd.acs_cmp = 1'b1;
                p_next  = p_reg + 3'd1;
                pv_next = pv_reg + SCNT_W'(1);
                br_next = br_reg + BCNT_W'(1);
                if ({1'b0, p_reg} == status.m - 4'd1)
                    state_next = ST_ACS_OUT;
                else
                    state_next = ST_ACS_RD;
            end
            ST_ACS_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.acs_out = 1'b1;
                    p_next      = '0;
                    if (s_last)
                    begin
                        s_next     = '0;
                        state_next = ST_CP_RD;
                    end
                    else
                    begin
                        s_next = s_reg + STATE_W'(1);
                        // next alphabet group starts over at predecessor 0
                        if (pv_reg == status.states)
                            pv_next = '0;
                        state_next = ST_ACS_RD;
                    end
                end
            end
            ST_CP_RD:
            begin
                cmd.cp_rd  = 1'b1;
                state_next = ST_CP_WR;
            end
            ST_CP_WR:
            begin
                cmd.cp_wr = 1'b1;
                if (s_last)
                    state_next = ST_IDLE;
                else
                begin
                    s_next     = s_reg + STATE_W'(1);
                    state_next = ST_CP_RD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/vbacs_datapath.sv
// Datapath: config registers, reference/metric memories, squared distance, ACS, output.
// Depends on vbacs_pkg; sequenced by vbacs_ctrl.
module vbacs_datapath
    import vbacs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_AW-1:0]     cfg_addr,
    input  logic [CFG_DW-1:0]     cfg_wdata,
    input  logic                  in_fire,
    input  logic [1:0]            in_user,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_last
);

    // configuration
    logic [3:0]  alpha_reg;
    logic [2:0]  memlen_reg;
    logic [5:0]  groups_reg;
    logic [8:0]  branches_reg;
    logic [3:0]  elems_reg;
    logic [15:0] blocksym_reg;
    logic        complex_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg    <= 4'd2;
            memlen_reg   <= 3'd2;
            groups_reg   <= 6'd1;
            branches_reg <= 9'd4;
            elems_reg    <= 4'd1;
            blocksym_reg <= 16'd64;
            complex_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_addr))
                REG_ALPHABET: alpha_reg    <= cfg_wdata[3:0];
                REG_MEMLEN:   memlen_reg   <= cfg_wdata[2:0];
                REG_GROUPS:   groups_reg   <= cfg_wdata[5:0];
                REG_BRANCHES: branches_reg <= cfg_wdata[8:0];
                REG_ELEMENTS: elems_reg    <= cfg_wdata[3:0];
                REG_BLOCKSYM: blocksym_reg <= cfg_wdata;
                REG_COMPLEX:  complex_reg  <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    // clamped working values
    logic [3:0] m_eff;
    logic [5:0] g_clamp, g_eff, g_lim;
    logic [3:0] ne_eff;
    logic [8:0] nb_eff;

    always_comb
    begin
        m_eff   = (alpha_reg < 4'd2) ? 4'd2 : ((alpha_reg > 4'd8) ? 4'd8 : alpha_reg);
        g_clamp = (groups_reg == 6'd0) ? 6'd1 : ((groups_reg > 6'd32) ? 6'd32 : groups_reg);
        g_lim   = max_groups(m_eff);
        g_eff   = (g_clamp > g_lim) ? g_lim : g_clamp;
        ne_eff  = (elems_reg == 4'd0) ? 4'd1 : ((elems_reg > 4'd8) ? 4'd8 : elems_reg);
        nb_eff  = (branches_reg == 9'd0) ? 9'd1 :
                  ((branches_reg > 9'd256) ? 9'd256 : branches_reg);
    end

    // input fields
    logic [1:0]           f_cmd;
    logic [ROW_W-1:0]     f_row;
    logic [ELEM_W-1:0]    f_elem;
    logic [15:0]          f_re, f_im;
    logic [STATE_W-1:0]   f_state;
    logic [METRIC_W-1:0]  f_metric;
    logic [15:0]          f_ktime;
    logic [ELEM_W-1:0]    ne_m1;

    assign f_cmd    = in_user;
    assign f_row    = in_data[8:0];
    assign f_elem   = in_data[11:9];
    assign f_re     = in_data[27:12];
    assign f_im     = in_data[43:28];
    assign f_state  = in_data[49:44];
    assign f_metric = in_data[97:50];
    assign f_ktime  = in_data[113:98];
    assign ne_m1    = ELEM_W'(ne_eff - 4'd1);

    logic out_valid_reg;

    always_comb
    begin
        status          = '0;
        status.trigger  = in_fire && (cmd_code_t'(f_cmd) == CMD_RX) && (f_elem == ne_m1);
        status.out_free = !out_valid_reg || out_ready;
        status.ne_m1    = ne_m1;
        status.nb       = nb_eff;
        status.m        = m_eff;
        status.states   = SCNT_W'(m_eff) * SCNT_W'(g_eff);
    end

    // received element buffer
    logic [15:0] rx_re_mem [MAX_ELEMENTS];
    logic [15:0] rx_im_mem [MAX_ELEMENTS];
    logic [15:0] ktime_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire && cmd_code_t'(f_cmd) == CMD_RX)
        begin
            rx_re_mem[f_elem] <= f_re;
            rx_im_mem[f_elem] <= f_im;
            ktime_reg         <= f_ktime;
        end
    end

    // reference table, {re, im} per entry
    logic [31:0] ref_mem [REF_ROWS*MAX_ELEMENTS];
    logic [31:0] ref_q_reg;
    logic [ROW_W-1:0] shift_reg, base_reg, row_sel;

    assign row_sel = base_reg + cmd.b[ROW_W-1:0];

    always_ff @(posedge clk)
    begin
        if (in_fire && cmd_code_t'(f_cmd) == CMD_LOAD_REF)
            ref_mem[{f_row, f_elem}] <= {f_re, f_im};
        if (cmd.bm_rd)
            ref_q_reg <= ref_mem[{row_sel, cmd.e}];
    end

    // reference row shift: k > L-2 ? (k < N ? L-1 : L+k-N) : k, taken mod 512
    logic signed [17:0] k_s, l_s, n_s, shift_s;

    always_comb
    begin
        k_s = $signed({2'b00, ktime_reg});
        l_s = $signed({15'd0, memlen_reg});
        n_s = $signed({2'b00, blocksym_reg});
        if (k_s > l_s - 18'sd2)
            shift_s = (k_s < n_s) ? (l_s - 18'sd1) : (l_s + k_s - n_s);
        else
            shift_s = k_s;
    end

    logic [17:0] base_prod;
    assign base_prod = shift_reg * nb_eff;

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
            shift_reg <= shift_s[ROW_W-1:0];
        if (cmd.base)
            base_reg <= base_prod[ROW_W-1:0];
    end

    // squared distance, accumulated over elements
    logic signed [16:0] d_re, d_im;
    logic signed [33:0] p_re, p_im;
    logic [SQ_W-1:0]    sq_re_reg, sq_im_reg;
    logic [ACC_W-1:0]   acc_reg, acc_sum;
    logic [BM_W-1:0]    bm_sat;

    assign d_re = $signed({ref_q_reg[31], ref_q_reg[31:16]})
                - $signed({rx_re_mem[cmd.e][15], rx_re_mem[cmd.e]});
    assign d_im = $signed({ref_q_reg[15], ref_q_reg[15:0]})
                - $signed({rx_im_mem[cmd.e][15], rx_im_mem[cmd.e]});
    assign p_re = d_re * d_re;
    assign p_im = d_im * d_im;

    assign acc_sum = (cmd.bm_first ? '0 : acc_reg)
                   + ACC_W'(sq_re_reg)
                   + (complex_reg ? ACC_W'(sq_im_reg) : '0);
    assign bm_sat  = acc_sum[ACC_W-1] ? '1 : acc_sum[BM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.bm_sq)
        begin
            sq_re_reg <= p_re[SQ_W-1:0];
            sq_im_reg <= p_im[SQ_W-1:0];
        end
        if (cmd.bm_acc)
            acc_reg <= acc_sum;
    end

    // branch metric memory
    logic [BM_W-1:0] bm_mem [MAX_BRANCHES];
    logic [BM_W-1:0] bm_q_reg;
    logic            br_ok_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.bm_acc && cmd.bm_wr)
            bm_mem[cmd.b[BIDX_W-1:0]] <= bm_sat;
        if (cmd.acs_rd)
        begin
            bm_q_reg  <= bm_mem[cmd.br[BIDX_W-1:0]];
            br_ok_reg <= (cmd.br < nb_eff);
        end
    end

    // running best candidate of the current state
    logic [METRIC_W-1:0] best_reg;
    logic [STATE_W-1:0]  bestp_reg;

    // path metrics; valid bits stand in for the zero reset
    logic [METRIC_W-1:0] pm_mem [MAX_STATES];
    logic [METRIC_W-1:0] pm_q_reg;
    logic                pm_q_ok_reg;
    logic [MAX_STATES-1:0] pm_valid_reg;
    logic [METRIC_W-1:0] park_mem [MAX_STATES];
    logic [METRIC_W-1:0] park_q_reg;
    logic                pm_set;

    assign pm_set = in_fire && cmd_code_t'(f_cmd) == CMD_SET_METRIC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pm_valid_reg <= '0;
        else if (pm_set)
            pm_valid_reg[f_state] <= 1'b1;
        else if (cmd.cp_wr)
            pm_valid_reg[cmd.s] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pm_set)
            pm_mem[f_state] <= f_metric;
        else if (cmd.cp_wr)
            pm_mem[cmd.s] <= park_q_reg;
        if (cmd.acs_rd)
        begin
            pm_q_reg    <= pm_mem[cmd.pv];
            pm_q_ok_reg <= pm_valid_reg[cmd.pv];
        end
        if (cmd.acs_out)
            park_mem[cmd.s] <= best_reg;
        if (cmd.cp_rd)
            park_q_reg <= park_mem[cmd.s];
    end

    // add-compare-select
    logic [METRIC_W:0]   cand_sum;
    logic [METRIC_W-1:0] cand;

    assign cand_sum = {1'b0, (pm_q_ok_reg ? pm_q_reg : '0)}
                    + (METRIC_W+1)'(br_ok_reg ? bm_q_reg : {BM_W{1'b1}});
    assign cand     = cand_sum[METRIC_W] ? '1 : cand_sum[METRIC_W-1:0];

    // cmd.pv still names the candidate read in the previous cycle
    always_ff @(posedge clk)
    begin
        if (cmd.acs_cmp && (cmd.acs_first || cand < best_reg))
        begin
            best_reg  <= cand;
            bestp_reg <= cmd.pv;
        end
    end

    // result register
    logic [STATE_W-1:0]  o_state_reg, o_prev_reg;
    logic [METRIC_W-1:0] o_metric_reg;
    logic                o_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.acs_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acs_out)
        begin
            o_state_reg  <= cmd.s;
            o_metric_reg <= best_reg;
            o_prev_reg   <= bestp_reg;
            o_last_reg   <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = o_last_reg;
    assign out_data  = {4'd0, o_prev_reg, o_metric_reg, o_state_reg};

endmodule

FILE: rtl/viterbi_branch_metric_acs.sv
// Top level of the Viterbi branch-metric / add-compare-select block.
// Depends on vbacs_pkg, vbacs_ctrl and vbacs_datapath.
//
// Usage:
//  - Input stream (s_*): tuser carries the command (load reference, set path
//    metric, received element, no-op). tdata carries the operands.
//    A received element stores into the rx buffer; the element with index
//    element_count-1 starts a trellis step.
//  - A trellis step first sets up the reference row shift and base, then forms
//    every branch metric with one shared squared-distance unit: for each element
//    of each branch it reads one reference entry from the reference RAM port,
//    squares the differences and accumulates before the next read. It then runs
//    ACS, reading and then comparing each predecessor candidate and emitting one
//    result per state, and ends with a per-state read and copy of the new metrics
//    back into the path metric RAM; s_tready is low for the whole step.
//  - Output stream (m_*): one item per state, in state order, tlast on the
//    last state. A one-deep result register holds an item while m_tready is
//    low; ACS stalls on it and resumes when the item is taken.
//  - Configuration (cfg_*): write only while idle, one register per cycle.
//  - Reset: config takes its defaults, all path metrics read as zero, the
//    output is empty. Reference and rx storage hold nothing until written.
module viterbi_branch_metric_acs
    import vbacs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_AW-1:0]     cfg_addr,
    input  logic [CFG_DW-1:0]     cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [8:0] ref_row, [11:9] elem_index, [27:12] sample_re, [43:28] sample_im,
    // [49:44] state_index, [97:50] metric_in, [113:98] symbol_time, rest zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [5:0] state_out, [53:6] new_metric, [59:54] prev_state, rest zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       idle;
    logic       in_fire;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && idle;

    vbacs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd),
        .idle   (idle)
    );

    vbacs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .in_user   (s_tuser),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    // a result is never loaded over one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acs_out |-> status.out_free)
        else $error("result register overwritten");

    // while a non-final result goes out the step is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |-> !s_tready)
        else $error("idle with results of a step outstanding");

    // the final result of a step is followed by the metric copy, not idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acs_out && cmd.last |=> !s_tready)
        else $error("step ended without metric write-back");

endmodule
